/* rtl/tspsd_pkg.sv */
package tspsd_pkg;

  // Stream constants
  localparam logic [7:0] SyncByte = 8'h47;
  localparam int unsigned WinLen = 417;
  localparam int unsigned CountW = 9;
  localparam int unsigned SkipLimit = 208;

  // Candidate packet lengths; each needs syncs at one and two lengths past the start
  localparam logic [7:0] Size188 = 8'd188;
  localparam logic [7:0] Size204 = 8'd204;
  localparam logic [7:0] Size208 = 8'd208;

  // Status codes as seen on the result stream
  localparam logic [1:0] StatusSearch = 2'd0;
  localparam logic [1:0] StatusLocked = 2'd1;
  localparam logic [1:0] StatusFailed = 2'd2;

  // Result transaction layout
  localparam int unsigned OutDataW = 16;

  typedef enum logic [2:0] {
    ST_SEARCH = 3'b001,
    ST_LOCKED = 3'b010,
    ST_FAILED = 3'b100
  } lock_state_e;

endpackage

/* rtl/ts_packet_size_sync_detect_top.sv */
// Transport stream packet length detector.
// Slave stream: one stream byte per transaction on s_axis_tdata_i; s_axis_tuser_i
// set restarts the search (state cleared first, then the byte is taken as the
// first byte of the new search).
// Master stream: one result per accepted byte, carrying the status (searching,
// locked, failed), the locked packet length (188, 204 or 208, else 0) and a
// lock flag raised on the byte that decided the lock.
// Throughput: one byte per cycle while s_axis_tready_o is high; each result is
// registered. All checks are fixed taps on a 417-flag shift register, evaluated
// between the input handshake and the result register.
// Stalls: with m_axis_tready_i low one further byte is taken into a skid
// register; s_axis_tready_o then drops until the output drains.
// Reset: the flag window, byte count, skip count and lock status are cleared
// and both output registers are emptied; bytes are accepted from the first
// cycle after reset.
module ts_packet_size_sync_detect_top #(
  parameter int unsigned SKIP_LIMIT = tspsd_pkg::SkipLimit
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [7:0]                      s_axis_tdata_i,  // [7:0] data_byte
  input  logic                            s_axis_tuser_i,  // [0] restart
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [1:0] status, [9:2] packet_size, [10] lock_now, [15:11] zero
  output logic [tspsd_pkg::OutDataW-1:0]  m_axis_tdata_o
);

  localparam int unsigned WinLen = tspsd_pkg::WinLen;
  localparam int unsigned CountW = tspsd_pkg::CountW;

  // Search state
  logic [WinLen-1:0]      win_q, win_d, win_eff, win_cand;
  logic [CountW-1:0]      bytes_q, bytes_d, bytes_eff;
  logic [7:0]             skip_q, skip_d, skip_eff;
  tspsd_pkg::lock_state_e state_q, state_d, state_eff;
  logic [7:0]             size_q, size_d, size_eff;

  logic                   in_fire;
  logic                   is_sync;
  logic                   lock_now;
  logic [1:0]             status_code;
  logic [tspsd_pkg::OutDataW-1:0] res_data;

  // Output register and skid stage
  logic                            out_valid_q, skid_valid_q;
  logic [tspsd_pkg::OutDataW-1:0]  out_data_q, skid_data_q;
  logic                            out_free;

  assign s_axis_tready_o = !skid_valid_q;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  assign is_sync = (s_axis_tdata_i == tspsd_pkg::SyncByte);

  // Restart clears the state before the byte is looked at
  assign win_eff   = s_axis_tuser_i ? '0 : win_q;
  assign bytes_eff = s_axis_tuser_i ? '0 : bytes_q;
  assign skip_eff  = s_axis_tuser_i ? '0 : skip_q;
  assign state_eff = s_axis_tuser_i ? tspsd_pkg::ST_SEARCH : state_q;
  assign size_eff  = s_axis_tuser_i ? '0 : size_q;

  // Window after shifting in this byte; bit 0 is the newest flag, the
  // candidate start sits at the top bit
  assign win_cand = {win_eff[WinLen-2:0], is_sync};

  function automatic logic at_off(input logic [WinLen-1:0] w, input int unsigned d);
    at_off = w[WinLen-1-d];
  endfunction

  // Candidate check and state update
  always_comb begin
    win_d    = win_eff;
    bytes_d  = bytes_eff;
    skip_d   = skip_eff;
    state_d  = state_eff;
    size_d   = size_eff;
    lock_now = 1'b0;
    if (state_eff == tspsd_pkg::ST_SEARCH) begin
      win_d = win_cand;
      if (bytes_eff < CountW'(WinLen)) begin
        bytes_d = bytes_eff + 1'b1;
      end
      if (bytes_eff >= CountW'(WinLen - 1)) begin
        if (skip_eff >= 8'(SKIP_LIMIT)) begin
          state_d = tspsd_pkg::ST_FAILED;
        end else if (!at_off(win_cand, 0)) begin
          skip_d = skip_eff + 1'b1;
        end else if (at_off(win_cand, 188) && at_off(win_cand, 376)) begin
          size_d   = tspsd_pkg::Size188;
          state_d  = tspsd_pkg::ST_LOCKED;
          lock_now = 1'b1;
        end else if (at_off(win_cand, 204) && at_off(win_cand, 408)) begin
          size_d   = tspsd_pkg::Size204;
          state_d  = tspsd_pkg::ST_LOCKED;
          lock_now = 1'b1;
        end else if (at_off(win_cand, 208) && at_off(win_cand, 416)) begin
          size_d   = tspsd_pkg::Size208;
          state_d  = tspsd_pkg::ST_LOCKED;
          lock_now = 1'b1;
        end else begin
          skip_d = skip_eff + 1'b1;
        end
      end
    end
  end

  // Status encoding for the result
  always_comb begin
    case (state_d)
      tspsd_pkg::ST_SEARCH: status_code = tspsd_pkg::StatusSearch;
      tspsd_pkg::ST_LOCKED: status_code = tspsd_pkg::StatusLocked;
      tspsd_pkg::ST_FAILED: status_code = tspsd_pkg::StatusFailed;
      default:              status_code = tspsd_pkg::StatusSearch;
    endcase
  end

  assign res_data = {5'b0, lock_now,
                     (state_d == tspsd_pkg::ST_LOCKED) ? size_d : 8'd0,
                     status_code};

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      bytes_q <= '0;
      skip_q  <= '0;
      state_q <= tspsd_pkg::ST_SEARCH;
      size_q  <= '0;
    end else if (in_fire) begin
      win_q   <= win_d;
      bytes_q <= bytes_d;
      skip_q  <= skip_d;
      state_q <= state_d;
      size_q  <= size_d;
    end
  end

  // Output valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_data_q <= skid_data_q;
      end else if (in_fire) begin
        out_data_q <= res_data;
      end
    end else if (in_fire) begin
      skid_data_q <= res_data;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

/* rtl/tspsd_checker.sv */
module tspsd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tready_o,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [tspsd_pkg::OutDataW-1:0]  m_axis_tdata_o
);

  // A length is reported exactly while locked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      ((m_axis_tdata_o[1:0] == tspsd_pkg::StatusLocked) == (m_axis_tdata_o[9:2] != 8'd0)))
    else $error("packet_size does not match lock status");

  // Lock flag only comes with a locked status and a valid length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[10]) |->
      (m_axis_tdata_o[1:0] == tspsd_pkg::StatusLocked &&
       (m_axis_tdata_o[9:2] == tspsd_pkg::Size188 ||
        m_axis_tdata_o[9:2] == tspsd_pkg::Size204 ||
        m_axis_tdata_o[9:2] == tspsd_pkg::Size208)))
    else $error("lock_now without a valid lock");

  // Status code is never the unused value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[1:0] != 2'd3))
    else $error("unused status code");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled result changed");

  // Input is refused only while a result waits on the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with empty output");

endmodule

bind ts_packet_size_sync_detect_top tspsd_checker u_tspsd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
